// File: src/dlhpt_pkg.sv
// Shared types and constants of the downlink HARQ process table.
package dlhpt_pkg;

  // Field widths that the interface fixes.
  localparam int FUNC_W  = 2;
  localparam int RNTI_W  = 16;
  localparam int PID_W   = 4;
  localparam int RV_W    = 2;
  localparam int BYTES_W = 18;
  localparam int SLOT_W  = 14;
  localparam int SB_W    = 21;
  localparam int CNT_W   = 32;
  localparam int BITS_W  = 48;
  localparam int PCNT_W  = 5;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // The SI-RNTI selects the broadcast process.
  localparam logic [RNTI_W-1:0] SI_RNTI = 16'hFFFF;

  // Bytes to bits is a left shift by this amount.
  localparam int BYTE_SHIFT = 3;

  // Item function codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_GRANT   = 2'd0,
    FUNC_RESULT  = 2'd1,
    FUNC_RESET   = 2'd2,
    FUNC_METRICS = 2'd3
  } func_t;

  // Register select, taken from address bit 2.
  typedef enum logic {
    REG_PROCESS_COUNT = 1'b0,
    REG_TEMP_CRNTI    = 1'b1
  } reg_sel_t;

  // Item as seen by the process table.
  typedef struct packed {
    logic              valid;
    func_t             func;
    logic [RNTI_W-1:0] rnti;
    logic [PID_W-1:0]  pid;
    logic              ndi;
    logic [RV_W-1:0]   rv;
    logic              ok;
    logic              payload;
  } table_req_t;

  // Decision that the process table returns for the current item.
  typedef struct packed {
    logic status;
    logic decode_enable;
    logic new_tx;
    logic duplicate;
    logic deliver;
    logic count_ok;
    logic count_fail;
  } verdict_t;

endpackage

// File: src/dl_harq_process_table_top.sv
// Top level of the downlink HARQ process table.
//
// Input channel (in_*): one transfer carries a grant, a decode result, a
// reset of all processes or a read-and-clear of the metrics counters.
// Result channel (out_*): exactly one result transfer per input transfer,
// in order. Both channels use valid/stall; a transfer happens on a clock
// edge with valid high and stall low.
// An accepted item is held in the input register, where a single-entry flag
// lookup decides it, and its result is then shown from the result register.
// Throughput is one item per cycle while the receiver does not stall; the
// flags are updated as the item moves to the result register, so the
// following item already sees them.
// When the receiver stalls, the result register holds and the input
// register fills; in_stall then rises until the result is taken.
// Reset (rst_n low, synchronous) empties both registers, restores all
// process flags and counters, and sets process_count to MAX_PROCS.
// The APB-style port holds process_count (address 0) and temporary_crnti
// (address 4); it may be written only while idle; the block does not enforce it.
module dl_harq_process_table_top #(
  parameter int MAX_PROCS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dlhpt_pkg::FUNC_W-1:0]  in_func,
  input  logic [dlhpt_pkg::RNTI_W-1:0]  in_rnti,
  input  logic [dlhpt_pkg::PID_W-1:0]   in_process_id,
  input  logic                          in_new_data_flag,
  input  logic [dlhpt_pkg::RV_W-1:0]    in_redundancy_version,
  input  logic [dlhpt_pkg::BYTES_W-1:0] in_block_bytes,
  input  logic                          in_decode_ok,
  input  logic                          in_payload_present,
  input  logic [dlhpt_pkg::SLOT_W-1:0]  in_slot_index,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_status,
  output logic                          out_decode_enable,
  output logic                          out_new_transmission,
  output logic [dlhpt_pkg::SB_W-1:0]    out_softbuffer_bits,
  output logic                          out_duplicate,
  output logic                          out_deliver_pdu,
  output logic [dlhpt_pkg::SLOT_W-1:0]  out_deliver_slot,
  output logic [dlhpt_pkg::CNT_W-1:0]   out_ok_count,
  output logic [dlhpt_pkg::CNT_W-1:0]   out_fail_count,
  output logic [dlhpt_pkg::BITS_W-1:0]  out_bit_count,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dlhpt_pkg::ADDR_W-1:0]  paddr,
  input  logic [dlhpt_pkg::DATA_W-1:0]  pwdata,
  output logic [dlhpt_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int PC_W = $clog2(MAX_PROCS + 1);

  // Configuration registers.
  logic [PC_W-1:0]              process_count_r;
  logic [dlhpt_pkg::RNTI_W-1:0] temp_crnti_r;
  logic                         cfg_wr;
  logic                         cfg_clear;
  logic [dlhpt_pkg::PCNT_W-1:0] pc_wdata;
  dlhpt_pkg::reg_sel_t          reg_sel;

  // Input register.
  logic                          s1_valid_r;
  logic [dlhpt_pkg::FUNC_W-1:0]  s1_func_r;
  logic [dlhpt_pkg::RNTI_W-1:0]  s1_rnti_r;
  logic [dlhpt_pkg::PID_W-1:0]   s1_pid_r;
  logic                          s1_ndi_r;
  logic [dlhpt_pkg::RV_W-1:0]    s1_rv_r;
  logic [dlhpt_pkg::BYTES_W-1:0] s1_bytes_r;
  logic                          s1_ok_r;
  logic                          s1_payload_r;
  logic [dlhpt_pkg::SLOT_W-1:0]  s1_slot_r;

  // Result register.
  logic                          out_valid_r;
  logic                          status_r;
  logic                          decode_enable_r;
  logic                          new_tx_r;
  logic [dlhpt_pkg::SB_W-1:0]    sb_bits_r;
  logic                          duplicate_r;
  logic                          deliver_r;
  logic [dlhpt_pkg::SLOT_W-1:0]  deliver_slot_r;
  logic [dlhpt_pkg::CNT_W-1:0]   ok_count_r;
  logic [dlhpt_pkg::CNT_W-1:0]   fail_count_r;
  logic [dlhpt_pkg::BITS_W-1:0]  bit_count_r;

  logic                          in_take;
  logic                          adv;
  logic                          is_metrics;
  dlhpt_pkg::table_req_t         req;
  dlhpt_pkg::verdict_t           verdict;
  logic [dlhpt_pkg::SB_W-1:0]    sb_bits;
  logic [dlhpt_pkg::CNT_W-1:0]   ok_count;
  logic [dlhpt_pkg::CNT_W-1:0]   fail_count;
  logic [dlhpt_pkg::BITS_W-1:0]  bit_count;

  // Configuration writes; an out-of-range process count is ignored.
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign reg_sel   = dlhpt_pkg::reg_sel_t'(paddr[2]);
  assign pc_wdata  = pwdata[dlhpt_pkg::PCNT_W-1:0];
  assign cfg_clear = cfg_wr && (reg_sel == dlhpt_pkg::REG_PROCESS_COUNT) &&
                     (pc_wdata != '0) && (int'(pc_wdata) <= MAX_PROCS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      process_count_r <= PC_W'(MAX_PROCS);
      temp_crnti_r    <= '0;
    end else begin
      if (cfg_clear) begin
        process_count_r <= PC_W'(pc_wdata);
      end
      if (cfg_wr && (reg_sel == dlhpt_pkg::REG_TEMP_CRNTI)) begin
        temp_crnti_r <= pwdata[dlhpt_pkg::RNTI_W-1:0];
      end
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_sel)
      dlhpt_pkg::REG_PROCESS_COUNT: prdata = dlhpt_pkg::DATA_W'(process_count_r);
      dlhpt_pkg::REG_TEMP_CRNTI:    prdata = dlhpt_pkg::DATA_W'(temp_crnti_r);
      default:                      prdata = '0;
    endcase
  end

  // Handshake: the item moves on when the result register is free or being taken.
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func_r    <= in_func;
      s1_rnti_r    <= in_rnti;
      s1_pid_r     <= in_process_id;
      s1_ndi_r     <= in_new_data_flag;
      s1_rv_r      <= in_redundancy_version;
      s1_bytes_r   <= in_block_bytes;
      s1_ok_r      <= in_decode_ok;
      s1_payload_r <= in_payload_present;
      s1_slot_r    <= in_slot_index;
    end
  end

  // Process lookup and flag update.
  assign req.valid   = adv;
  assign req.func    = dlhpt_pkg::func_t'(s1_func_r);
  assign req.rnti    = s1_rnti_r;
  assign req.pid     = s1_pid_r;
  assign req.ndi     = s1_ndi_r;
  assign req.rv      = s1_rv_r;
  assign req.ok      = s1_ok_r;
  assign req.payload = s1_payload_r;

  dlhpt_proc_table #(
    .MAX_PROCS(MAX_PROCS)
  ) u_table (
    .clk             (clk),
    .rst_n           (rst_n),
    .req             (req),
    .process_count   (process_count_r),
    .temporary_crnti (temp_crnti_r),
    .cfg_clear       (cfg_clear),
    .verdict         (verdict)
  );

  // Statistics.
  assign sb_bits    = {s1_bytes_r, {dlhpt_pkg::BYTE_SHIFT{1'b0}}};
  assign is_metrics = (req.func == dlhpt_pkg::FUNC_METRICS);

  dlhpt_metrics u_metrics (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (adv && is_metrics),
    .count_ok   (adv && verdict.count_ok),
    .count_fail (adv && verdict.count_fail),
    .add_bits   (sb_bits),
    .ok_count   (ok_count),
    .fail_count (fail_count),
    .bit_count  (bit_count)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r        <= verdict.status;
      decode_enable_r <= verdict.decode_enable;
      new_tx_r        <= verdict.new_tx;
      sb_bits_r       <= verdict.new_tx ? sb_bits : '0;
      duplicate_r     <= verdict.duplicate;
      deliver_r       <= verdict.deliver;
      deliver_slot_r  <= verdict.deliver ? s1_slot_r : '0;
      ok_count_r      <= is_metrics ? ok_count : '0;
      fail_count_r    <= is_metrics ? fail_count : '0;
      bit_count_r     <= is_metrics ? bit_count : '0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_decode_enable    = decode_enable_r;
  assign out_new_transmission = new_tx_r;
  assign out_softbuffer_bits  = sb_bits_r;
  assign out_duplicate        = duplicate_r;
  assign out_deliver_pdu      = deliver_r;
  assign out_deliver_slot     = deliver_slot_r;
  assign out_ok_count         = ok_count_r;
  assign out_fail_count       = fail_count_r;
  assign out_bit_count        = bit_count_r;

  // The input side only stalls while the input register holds an item.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("in_stall high with an empty input register");

  // An unconfigured process result carries no other decision.
  a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |->
      (!out_decode_enable && !out_duplicate && !out_deliver_pdu && !out_new_transmission))
    else $error("status result with other flags set");

  // A soft buffer reset always goes with decoding, and never with a duplicate.
  a_newtx_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_new_transmission) |-> (out_decode_enable && !out_duplicate))
    else $error("new transmission without decode enable");

  // A metrics read leaves all counters cleared.
  a_metrics_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && is_metrics) |=> ((ok_count == '0) && (fail_count == '0) && (bit_count == '0)))
    else $error("counters not cleared after a metrics read");

endmodule

// File: src/dlhpt_proc_table.sv
// Per-process HARQ flags, temporary C-RNTI tracking and the grant/result decision.
module dlhpt_proc_table #(
  parameter int MAX_PROCS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dlhpt_pkg::table_req_t         req,
  input  logic [$clog2(MAX_PROCS+1)-1:0] process_count,
  input  logic [dlhpt_pkg::RNTI_W-1:0]  temporary_crnti,
  input  logic                          cfg_clear,
  output dlhpt_pkg::verdict_t           verdict
);

  localparam int PW = $clog2(MAX_PROCS + 1);

  // Entry MAX_PROCS is the broadcast process.
  logic [MAX_PROCS:0] ndi_r, ndi_nxt;
  logic [MAX_PROCS:0] first_r, first_nxt;
  logic [MAX_PROCS:0] acked_r, acked_nxt;
  logic [dlhpt_pkg::RNTI_W-1:0] last_temp_id_r, last_temp_id_nxt;

  logic          bcch;
  logic          unconf;
  logic [PW-1:0] p;
  logic          tc_hit;
  logic          toggled;
  logic          new_tx;
  logic          good_pdu;

  // Process lookup and the decision for the current item.
  assign bcch     = (req.rnti == dlhpt_pkg::SI_RNTI);
  assign unconf   = !bcch && ((int'(req.pid) >= int'(process_count)) ||
                              (int'(req.pid) >= MAX_PROCS));
  assign p        = bcch ? PW'(MAX_PROCS) : PW'(req.pid);
  assign tc_hit   = (req.rnti == temporary_crnti) && (last_temp_id_r != temporary_crnti);
  assign toggled  = (req.ndi != ndi_r[p]) || tc_hit;
  assign new_tx   = toggled || (bcch && (req.rv == '0)) || first_r[p];
  assign good_pdu = req.ok && req.payload;

  always_comb begin
    verdict = '0;
    if ((req.func == dlhpt_pkg::FUNC_GRANT) || (req.func == dlhpt_pkg::FUNC_RESULT)) begin
      if (unconf) begin
        verdict.status = 1'b1;
      end else if (req.func == dlhpt_pkg::FUNC_GRANT) begin
        verdict.new_tx        = new_tx;
        verdict.decode_enable = new_tx || !acked_r[p];
        verdict.duplicate     = !new_tx && acked_r[p];
      end else begin
        verdict.deliver    = good_pdu && !bcch && (req.rnti != temporary_crnti);
        verdict.count_ok   = good_pdu;
        verdict.count_fail = !good_pdu;
      end
    end
  end

  // Next state of the flags.
  always_comb begin
    ndi_nxt          = ndi_r;
    first_nxt        = first_r;
    acked_nxt        = acked_r;
    last_temp_id_nxt = last_temp_id_r;
    if (cfg_clear) begin
      for (int i = 0; i < MAX_PROCS; i++) begin
        ndi_nxt[i]   = 1'b0;
        first_nxt[i] = 1'b1;
        acked_nxt[i] = 1'b0;
      end
    end else if (req.valid) begin
      case (req.func)
        dlhpt_pkg::FUNC_RESET: begin
          for (int i = 0; i < MAX_PROCS; i++) begin
            if (i < int'(process_count)) begin
              ndi_nxt[i]   = 1'b0;
              first_nxt[i] = 1'b1;
            end
          end
          ndi_nxt[MAX_PROCS]   = 1'b0;
          first_nxt[MAX_PROCS] = 1'b1;
        end
        dlhpt_pkg::FUNC_GRANT: begin
          if (!unconf) begin
            if (tc_hit) begin
              last_temp_id_nxt = temporary_crnti;
            end
            if (new_tx) begin
              first_nxt[p] = 1'b0;
            end
            ndi_nxt[p] = req.ndi;
          end
        end
        dlhpt_pkg::FUNC_RESULT: begin
          if (!unconf) begin
            acked_nxt[p] = req.ok;
            // A good broadcast block restarts the broadcast process.
            if (good_pdu && bcch) begin
              ndi_nxt[p]   = 1'b0;
              first_nxt[p] = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Flag storage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ndi_r          <= '0;
      first_r        <= '1;
      acked_r        <= '0;
      last_temp_id_r <= '0;
    end else begin
      ndi_r          <= ndi_nxt;
      first_r        <= first_nxt;
      acked_r        <= acked_nxt;
      last_temp_id_r <= last_temp_id_nxt;
    end
  end

endmodule

// File: src/dlhpt_metrics.sv
// Decode statistics counters with read-and-clear.
module dlhpt_metrics (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clear,
  input  logic                         count_ok,
  input  logic                         count_fail,
  input  logic [dlhpt_pkg::SB_W-1:0]   add_bits,
  output logic [dlhpt_pkg::CNT_W-1:0]  ok_count,
  output logic [dlhpt_pkg::CNT_W-1:0]  fail_count,
  output logic [dlhpt_pkg::BITS_W-1:0] bit_count
);

  logic [dlhpt_pkg::CNT_W-1:0]  ok_r, ok_nxt;
  logic [dlhpt_pkg::CNT_W-1:0]  fail_r, fail_nxt;
  logic [dlhpt_pkg::BITS_W-1:0] bits_r, bits_nxt;

  // Counters wrap at their widths; a read clears all three.
  always_comb begin
    ok_nxt   = ok_r;
    fail_nxt = fail_r;
    bits_nxt = bits_r;
    if (clear) begin
      ok_nxt   = '0;
      fail_nxt = '0;
      bits_nxt = '0;
    end else begin
      if (count_ok) begin
        ok_nxt   = ok_r + 1'b1;
        bits_nxt = bits_r + dlhpt_pkg::BITS_W'(add_bits);
      end
      if (count_fail) begin
        fail_nxt = fail_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r   <= '0;
      fail_r <= '0;
      bits_r <= '0;
    end else begin
      ok_r   <= ok_nxt;
      fail_r <= fail_nxt;
      bits_r <= bits_nxt;
    end
  end

  assign ok_count   = ok_r;
  assign fail_count = fail_r;
  assign bit_count  = bits_r;

endmodule
